[design/ttw_pkg.sv]
// Shared types and constants for the text-mode terminal writer.
// Used by ttw_screen, ttw_ctrl and the top module; depends on nothing.
`default_nettype none

package ttw_pkg;

	localparam logic [1:0] REQ_PUT   = 2'd0;
	localparam logic [1:0] REQ_CLEAR = 2'd1;
	localparam logic [1:0] REQ_SET   = 2'd2;
	localparam logic [1:0] REQ_READ  = 2'd3;

	localparam logic [7:0] CH_BACKSPACE = 8'd8;
	localparam logic [7:0] CH_NEWLINE   = 8'd10;
	localparam logic [7:0] CH_RETURN    = 8'd13;
	localparam logic [7:0] CH_SPACE     = 8'd32;

	localparam logic [15:0] RESET_CELL = 16'h0A20;

	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 4;
	localparam logic [CFG_IDX_W-1:0] CFG_FG = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_BG = 1'b1;
	localparam logic [3:0] FG_RESET = 4'd10;
	localparam logic [3:0] BG_RESET = 4'd0;

	typedef struct packed {
		logic [1:0] req_type;
		logic [7:0] char_code;
		logic [4:0] target_row;
		logic [6:0] target_col;
	} in_word_t;

	typedef struct packed {
		logic [4:0]  cursor_row;
		logic [6:0]  cursor_col;
		logic [10:0] cursor_pos;
		logic [15:0] cell_value;
		logic        scrolled;
	} out_word_t;

	typedef struct packed {
		logic wr_en;
		logic rd_en;
	} mem_ctl_t;

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_EXEC,
		ST_CLEAR,
		ST_SCROLL,
		ST_BLANK
	} state_t;

endpackage

`default_nettype wire

[design/ttw_addr.sv]
// Shared address unit: linear cell position row * columns + column.
// Depends on nothing but its parameters.
`default_nettype none

module ttw_addr #(
	parameter int SCREEN_COLS = 80,
	parameter int RW = 5,
	parameter int CW = 7,
	parameter int AW = 11
) (
	input  wire logic [RW-1:0] row,
	input  wire logic [CW-1:0] col,
	output logic      [AW-1:0] addr
);

	assign addr = AW'(32'(row) * SCREEN_COLS + 32'(col));

endmodule

`default_nettype wire

[design/ttw_screen.sv]
// Screen cell store: one write port and one registered read port.
// Depends on ttw_pkg for the port control struct.
`default_nettype none

module ttw_screen import ttw_pkg::*; #(
	parameter int DEPTH = 2000,
	parameter int AW = 11
) (
	input  wire logic          clk,
	input  wire mem_ctl_t      mem_ctl,
	input  wire logic [AW-1:0] wr_addr,
	input  wire logic [15:0]   wr_data,
	input  wire logic [AW-1:0] rd_addr,
	output logic      [15:0]   rd_data
);

	logic [15:0] mem_q [DEPTH];
	logic [15:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (mem_ctl.wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_ctl.rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

`default_nettype wire

[design/ttw_ctrl.sv]
// Request sequencer: cursor state, store sweeps for clear and scroll, output register.
// Depends on ttw_pkg and instantiates the shared address unit ttw_addr.
`default_nettype none

module ttw_ctrl import ttw_pkg::*; #(
	parameter int SCREEN_COLS = 80,
	parameter int SCREEN_ROWS = 25,
	parameter int AW = 11
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	input  wire in_word_t      in_word,
	output logic               out_valid,
	input  wire logic          out_ready,
	output out_word_t          out_word,
	input  wire logic [7:0]    attr,
	output mem_ctl_t           mem_ctl,
	output logic      [AW-1:0] wr_addr,
	output logic      [15:0]   wr_data,
	output logic      [AW-1:0] rd_addr,
	input  wire logic [15:0]   rd_data
);

	localparam int RW = $clog2(SCREEN_ROWS);
	localparam int CW = $clog2(SCREEN_COLS);
	localparam int LAST_CELL = SCREEN_ROWS * SCREEN_COLS - 1;
	localparam int COPY_LAST = (SCREEN_ROWS - 1) * SCREEN_COLS - 1;

	state_t          state_q, state_d;
	in_word_t        req_q;
	logic [RW-1:0]   row_q;
	logic [CW-1:0]   col_q;
	logic [AW-1:0]   cnt_q;
	logic            copy_vld_s1;
	logic [AW-1:0]   copy_addr_s1;
	logic            pend_q, pend_read_q, pend_scroll_q;
	logic            out_valid_q;
	out_word_t       out_word_q;

	logic [RW-1:0]   tgt_row, unit_row, nxt_row;
	logic [CW-1:0]   tgt_col, unit_col, nxt_col;
	logic [AW-1:0]   unit_addr;
	logic [CW:0]     col_inc;
	logic            at_last_row, line_end;
	logic            is_put, is_nl, is_cr, is_bs, is_print, is_read, is_clear;
	logic            advance, exec_scroll;
	logic            out_free, flush;
	logic [15:0]     blank_cell;

	ttw_addr #(
		.SCREEN_COLS(SCREEN_COLS),
		.RW(RW),
		.CW(CW),
		.AW(AW)
	) u_addr (
		.row(unit_row),
		.col(unit_col),
		.addr(unit_addr)
	);

	assign blank_cell = {attr, CH_SPACE};
	assign out_free   = !out_valid_q || out_ready;
	assign flush      = (state_q == ST_IDLE) && pend_q && out_free;

	always_comb begin
		tgt_row = (32'(req_q.target_row) > SCREEN_ROWS - 1) ? RW'(SCREEN_ROWS - 1)
			: RW'(req_q.target_row);
		tgt_col = (32'(req_q.target_col) > SCREEN_COLS - 1) ? CW'(SCREEN_COLS - 1)
			: CW'(req_q.target_col);
		col_inc     = (CW+1)'(col_q) + (CW+1)'(1);
		at_last_row = (32'(row_q) == SCREEN_ROWS - 1);
		line_end    = (col_inc == (CW+1)'(SCREEN_COLS));
		is_put      = (req_q.req_type == REQ_PUT);
		is_read     = (req_q.req_type == REQ_READ);
		is_clear    = (req_q.req_type == REQ_CLEAR);
		is_nl       = is_put && (req_q.char_code == CH_NEWLINE);
		is_cr       = is_put && (req_q.char_code == CH_RETURN);
		is_bs       = is_put && (req_q.char_code == CH_BACKSPACE);
		is_print    = is_put && !is_nl && !is_cr && !is_bs;
		advance     = is_nl || (is_print && line_end);
		exec_scroll = advance && at_last_row;

		nxt_row = row_q;
		nxt_col = col_q;
		case (req_q.req_type)
			REQ_PUT: begin
				if (is_nl || is_cr) begin
					nxt_col = '0;
				end else if (is_bs) begin
					if (col_q != '0) begin
						nxt_col = col_q - CW'(1);
					end
				end else begin
					nxt_col = line_end ? '0 : CW'(col_inc);
				end
				if (advance && !at_last_row) begin
					nxt_row = row_q + RW'(1);
				end
			end
			REQ_CLEAR: begin
				nxt_row = '0;
				nxt_col = '0;
			end
			REQ_SET: begin
				nxt_row = tgt_row;
				nxt_col = tgt_col;
			end
			default: begin
			end
		endcase

		unit_row = row_q;
		unit_col = col_q;
		if (state_q == ST_EXEC) begin
			if (is_read) begin
				unit_row = tgt_row;
				unit_col = tgt_col;
			end else if (is_bs) begin
				unit_col = col_q - CW'(1);
			end
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_INIT: begin
				if (cnt_q == AW'(LAST_CELL)) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (in_valid && in_ready) state_d = ST_EXEC;
			end
			ST_EXEC: begin
				if (is_clear) state_d = ST_CLEAR;
				else if (exec_scroll) state_d = ST_SCROLL;
				else state_d = ST_IDLE;
			end
			ST_CLEAR: begin
				if (cnt_q == AW'(LAST_CELL)) state_d = ST_IDLE;
			end
			ST_SCROLL: begin
				if (cnt_q == AW'(COPY_LAST)) state_d = ST_BLANK;
			end
			ST_BLANK: begin
				if (!copy_vld_s1 && cnt_q == AW'(LAST_CELL)) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready = 1'b0;
		mem_ctl  = '0;
		wr_addr  = cnt_q;
		wr_data  = blank_cell;
		rd_addr  = unit_addr;
		case (state_q)
			ST_INIT: begin
				mem_ctl.wr_en = 1'b1;
				wr_data       = RESET_CELL;
			end
			ST_IDLE: begin
				in_ready = !pend_q || out_free;
			end
			ST_EXEC: begin
				if (is_read) begin
					mem_ctl.rd_en = 1'b1;
				end else if (is_bs && col_q != '0) begin
					mem_ctl.wr_en = 1'b1;
					wr_addr       = unit_addr;
				end else if (is_print) begin
					mem_ctl.wr_en = 1'b1;
					wr_addr       = unit_addr;
					wr_data       = {attr, req_q.char_code};
				end
			end
			ST_CLEAR: begin
				mem_ctl.wr_en = 1'b1;
			end
			ST_SCROLL: begin
				mem_ctl.rd_en = 1'b1;
				rd_addr       = cnt_q + AW'(SCREEN_COLS);
				mem_ctl.wr_en = copy_vld_s1;
				wr_addr       = copy_addr_s1;
				wr_data       = rd_data;
			end
			ST_BLANK: begin
				mem_ctl.wr_en = 1'b1;
				if (copy_vld_s1) begin
					wr_addr = copy_addr_s1;
					wr_data = rd_data;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_INIT;
			row_q         <= '0;
			col_q         <= '0;
			cnt_q         <= '0;
			copy_vld_s1   <= 1'b0;
			pend_q        <= 1'b0;
			pend_read_q   <= 1'b0;
			pend_scroll_q <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			state_q     <= state_d;
			copy_vld_s1 <= (state_q == ST_SCROLL);

			case (state_q)
				ST_EXEC: begin
					cnt_q <= '0;
					row_q <= nxt_row;
					col_q <= nxt_col;
				end
				ST_INIT, ST_CLEAR, ST_SCROLL: begin
					cnt_q <= cnt_q + AW'(1);
				end
				ST_BLANK: begin
					if (!copy_vld_s1) cnt_q <= cnt_q + AW'(1);
				end
				default: begin
				end
			endcase

			if (state_q != ST_IDLE && state_q != ST_INIT && state_d == ST_IDLE) begin
				pend_q        <= 1'b1;
				pend_read_q   <= (state_q == ST_EXEC) && is_read;
				pend_scroll_q <= (state_q == ST_BLANK);
			end else if (flush) begin
				pend_q <= 1'b0;
			end

			if (flush) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		copy_addr_s1 <= cnt_q;
		if (state_q == ST_IDLE && in_valid && in_ready) begin
			req_q <= in_word;
		end
		if (flush) begin
			out_word_q.cursor_row <= 5'(row_q);
			out_word_q.cursor_col <= 7'(col_q);
			out_word_q.cursor_pos <= 11'(unit_addr);
			out_word_q.cell_value <= pend_read_q ? rd_data : 16'd0;
			out_word_q.scrolled   <= pend_scroll_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_word  = out_word_q;

`ifndef NO_ASSERTIONS
	a_cursor_range: assert property (@(posedge clk) disable iff (!arst_n)
		32'(row_q) < SCREEN_ROWS && 32'(col_q) < SCREEN_COLS)
		else $error("cursor left the screen");

	a_accept_exec: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> state_q == ST_EXEC)
		else $error("accepted word did not start execution");

	a_copy_window: assert property (@(posedge clk) disable iff (!arst_n)
		copy_vld_s1 |-> state_q == ST_SCROLL || state_q == ST_BLANK)
		else $error("scroll copy write outside the scroll sweep");

	a_scroll_cursor: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q && pend_scroll_q |-> col_q == '0 && 32'(row_q) == SCREEN_ROWS - 1)
		else $error("scroll left the cursor off the bottom line start");
`endif

endmodule

`default_nettype wire

[design/text_mode_terminal_writer_top.sv]
// A put, set-cursor or read word passes through the execute state and then the output register;
// a new word is taken only in the idle state, once any pending result can move to the output.
// A clear walks the whole store writing blanks; a scroll adds a copy sweep that moves each row
// up by one line, then a blank of the bottom line.
// After reset the store is filled with blanks before any word is taken.
// Depends on ttw_pkg, ttw_ctrl, ttw_screen; holds the color registers.
`default_nettype none

module text_mode_terminal_writer_top import ttw_pkg::*; #(
	parameter int SCREEN_COLS = 80,
	parameter int SCREEN_ROWS = 25
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire in_word_t              in_word,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output out_word_t                  out_word,
	input  wire logic                  cfg_wr_en,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

	localparam int AW = $clog2(SCREEN_ROWS * SCREEN_COLS);

	logic [3:0]    fg_q, bg_q;
	mem_ctl_t      mem_ctl;
	logic [AW-1:0] wr_addr, rd_addr;
	logic [15:0]   wr_data, rd_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fg_q <= FG_RESET;
			bg_q <= BG_RESET;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				CFG_FG:  fg_q <= cfg_wdata;
				CFG_BG:  bg_q <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	ttw_ctrl #(
		.SCREEN_COLS(SCREEN_COLS),
		.SCREEN_ROWS(SCREEN_ROWS),
		.AW(AW)
	) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_word(in_word),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_word(out_word),
		.attr({bg_q, fg_q}),
		.mem_ctl(mem_ctl),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	ttw_screen #(
		.DEPTH(SCREEN_ROWS * SCREEN_COLS),
		.AW(AW)
	) u_screen (
		.clk(clk),
		.mem_ctl(mem_ctl),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

endmodule

`default_nettype wire
